// ----- rtl/core/brfp_pkg.sv -----
`timescale 1ns / 1ps
package brfp_pkg;

   localparam int SLOT_COUNT_DEF = 256;

   // csr map: one byte register per word
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [7:0] CAPACITY_RST = 8'd255;

   localparam logic [3:0] ACT_PUT = 4'd0;
   localparam logic [3:0] ACT_GET = 4'd1;
   localparam logic [3:0] ACT_PEEK = 4'd2;
   localparam logic [3:0] ACT_NEXT = 4'd3;
   localparam logic [3:0] ACT_SKIP = 4'd4;
   localparam logic [3:0] ACT_PEEK_AT = 4'd5;
   localparam logic [3:0] ACT_ADV_WRITE = 4'd6;
   localparam logic [3:0] ACT_ADV_READ = 4'd7;
   localparam logic [3:0] ACT_CLEAR = 4'd8;

   // where the result byte comes from
   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_ECHO = 2'd1;
   localparam logic [1:0] SRC_RAM = 2'd2;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] data;
      logic [7:0] amount;
      logic [7:0] offset;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       ok;
      logic [7:0] leftover;
      logic [7:0] used_count;
      logic [7:0] free_count;
      logic       is_empty;
      logic       is_full;
   } rsp_payload_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] leftover;
      logic [1:0] byte_src;
      logic [7:0] echo;
   } pend_type;

endpackage

// ----- rtl/core/byte_ring_fifo_with_peek_unit.sv -----
`timescale 1ns / 1ps
// byte ring fifo with peek, bulk pointer advances and clear
// requests come in on req_valid/req_ready, one action each; every request
// gives exactly one response on rsp_valid/rsp_ready, in order
// a request runs through the idle and done states: the accept cycle decides the
// action, moves the pointers and starts the slot ram access, the done state picks
// up the ram read data and loads the response register; so no new request is
// taken until the done state has passed, as the slot ram read is registered
// the response register frees the channel: a new request is taken while
// the previous response is being taken in the same cycle; while the
// receiver stalls, req_ready stays low
// capacity is written through the apb port and takes effect at the next
// clear request; ring size is capacity plus one, limited to SLOT_COUNT
// reset empties the fifo, sets capacity to 255 and needs no clearing pass;
// slot contents are undefined until written
module byte_ring_fifo_with_peek_unit
   import brfp_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int RING_MAX = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
   localparam int ADDR_W = $clog2(RING_MAX);
   localparam logic [8:0] RING_MAX_W = 9'(RING_MAX);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DONE = 1'b1;

   logic            state_ff, state_in;
   logic [7:0]      head_ff, head_in;
   logic [7:0]      tail_ff, tail_in;
   logic [8:0]      rsize_ff, rsize_in;
   logic [7:0]      capacity_ff, capacity_in;
   pend_type        pend_ff, pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            accept;
   logic            csr_write;
   logic [7:0]      used_now;
   logic [7:0]      room_now;
   logic [8:0]      cap_plus;
   logic [7:0]      step;
   logic            ram_wr_en;
   logic            ram_rd_en;
   logic [7:0]      ram_rd_index;
   logic [7:0]      ram_rd_data;

   function automatic logic [7:0] bump(input logic [7:0] idx, input logic [7:0] by,
                                       input logic [8:0] rsize);
      logic [8:0] sum;
      sum = {1'b0, idx} + {1'b0, by};
      if (sum >= rsize) begin
         sum = sum - rsize;
      end
      return sum[7:0];
   endfunction

   brfp_ram #(
      .WIDTH (8),
      .DEPTH (RING_MAX)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff[ADDR_W-1:0]),
      .wr_data (req_payload.data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_index[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata = (paddr[CSR_ADDR_W-1] == REG_CAPACITY) ? {24'd0, capacity_ff} : 32'd0;

   // counts from the registered pointers
   always_comb begin
      if (tail_ff >= head_ff) begin
         used_now = tail_ff - head_ff;
      end else begin
         used_now = 8'(({1'b0, tail_ff} + rsize_ff) - {1'b0, head_ff});
      end
      room_now = 8'(rsize_ff - 9'd1 - {1'b0, used_now});
   end

   assign cap_plus = {1'b0, capacity_ff} + 9'd1;

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      rsize_in = rsize_ff;
      capacity_in = capacity_ff;
      pend_in = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      ram_rd_index = head_ff;
      step = 8'd0;

      if (csr_write && paddr[CSR_ADDR_W-1] == REG_CAPACITY) begin
         capacity_in = pwdata[7:0];
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DONE;
               pend_in.ok = 1'b0;
               pend_in.leftover = 8'd0;
               pend_in.byte_src = SRC_ZERO;
               pend_in.echo = req_payload.data;
               case (req_payload.action)
                  ACT_PUT: begin
                     if (room_now != 8'd0) begin
                        ram_wr_en = 1'b1;
                        tail_in = bump(tail_ff, 8'd1, rsize_ff);
                        pend_in.ok = 1'b1;
                        pend_in.byte_src = SRC_ECHO;
                     end
                  end
                  ACT_GET: begin
                     if (used_now != 8'd0) begin
                        ram_rd_en = 1'b1;
                        head_in = bump(head_ff, 8'd1, rsize_ff);
                        pend_in.ok = 1'b1;
                        pend_in.byte_src = SRC_RAM;
                     end
                  end
                  ACT_PEEK: begin
                     if (used_now != 8'd0) begin
                        ram_rd_en = 1'b1;
                        pend_in.ok = 1'b1;
                        pend_in.byte_src = SRC_RAM;
                     end
                  end
                  ACT_NEXT, ACT_SKIP: begin
                     if (used_now != 8'd0) begin
                        head_in = bump(head_ff, 8'd1, rsize_ff);
                        ram_rd_index = head_in;
                        // still holding data after the pop
                        if (used_now != 8'd1) begin
                           pend_in.ok = 1'b1;
                           if (req_payload.action == ACT_NEXT) begin
                              ram_rd_en = 1'b1;
                              pend_in.byte_src = SRC_RAM;
                           end
                        end
                     end
                  end
                  ACT_PEEK_AT: begin
                     ram_rd_index = bump(head_ff, req_payload.offset, rsize_ff);
                     if (req_payload.offset < used_now) begin
                        ram_rd_en = 1'b1;
                        pend_in.ok = 1'b1;
                        pend_in.byte_src = SRC_RAM;
                     end
                  end
                  ACT_ADV_WRITE: begin
                     step = (req_payload.amount < room_now) ? req_payload.amount : room_now;
                     tail_in = bump(tail_ff, step, rsize_ff);
                     pend_in.leftover = req_payload.amount - step;
                     pend_in.ok = 1'b1;
                  end
                  ACT_ADV_READ: begin
                     step = (req_payload.amount < used_now) ? req_payload.amount : used_now;
                     head_in = bump(head_ff, step, rsize_ff);
                     pend_in.leftover = req_payload.amount - step;
                     pend_in.ok = 1'b1;
                  end
                  ACT_CLEAR: begin
                     head_in = 8'd0;
                     tail_in = 8'd0;
                     rsize_in = (cap_plus > RING_MAX_W) ? RING_MAX_W : cap_plus;
                     pend_in.ok = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DONE: begin
            // response register is free here: it was free or taken at accept
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (pend_ff.byte_src)
               SRC_ECHO: rsp_payload_in.byte_out = pend_ff.echo;
               SRC_RAM:  rsp_payload_in.byte_out = ram_rd_data;
               default:  rsp_payload_in.byte_out = 8'd0;
            endcase
            rsp_payload_in.ok = pend_ff.ok;
            rsp_payload_in.leftover = pend_ff.leftover;
            rsp_payload_in.used_count = used_now;
            rsp_payload_in.free_count = room_now;
            rsp_payload_in.is_empty = (used_now == 8'd0);
            rsp_payload_in.is_full = (room_now == 8'd0);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= 8'd0;
         tail_ff <= 8'd0;
         rsize_ff <= RING_MAX_W;
         capacity_ff <= CAPACITY_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         rsize_ff <= rsize_in;
         capacity_ff <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ----- rtl/core/brfp_ram.sv -----
`timescale 1ns / 1ps
module brfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
